FILE: src/lnos_pkg.sv
// Package: shared constants, configuration types and codes for the nearest-obstacle steering block.
package lnos_pkg;

  localparam int MAX_SAMPLES_DEF = 2048;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 24;
  localparam int RANGE_W         = 17;

  localparam logic [RANGE_W-1:0] RANGE_INF      = 17'h1FFFF;
  localparam logic [RANGE_W-1:0] RANGE_FAR      = 17'h10000;
  localparam logic [15:0]        RANGE_SHORT_MM = 16'd50;
  localparam logic [RANGE_W-1:0] FOLLOW_MIN_MM  = 17'd350;
  localparam int                 PI_URAD        = 3141593;
  localparam int                 TWO_PI_URAD    = 6283185;
  localparam int                 TEN_DEG_URAD   = 174533;
  localparam logic [19:0]        CRAWL_UMPS     = 20'd10000;
  localparam logic [31:0]        AVOID_HOLD_MS  = 32'd800;
  localparam logic [31:0]        TRACK_HOLD_MS  = 32'd400;

  // ceil(2^24 / 6): speed / 6 as a multiply and shift, exact below 2^23
  localparam logic [21:0]        DIV6_RECIP     = 22'd2796203;
  localparam int                 DIV6_SHIFT     = 24;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_AVOID  = 2'd1,
    MODE_FOLLOW = 2'd2,
    MODE_GUARD  = 2'd3
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RUN_MODE   = 3'd0,
    CFG_NEAR_MM    = 3'd1,
    CFG_CONE_URAD  = 3'd2,
    CFG_BASE_UMPS  = 3'd3,
    CFG_START_URAD = 3'd4,
    CFG_STEP_URAD  = 3'd5
  } cfg_addr_t;

  typedef struct packed {
    mode_t              run_mode;
    logic [10:0]        near_threshold_mm;
    logic [22:0]        cone_width_urad;
    logic [19:0]        base_speed_umps;
    logic signed [23:0] scan_start_urad;
    logic [15:0]        scan_step_urad;
  } cfg_t;

endpackage

FILE: src/lnos_if.sv
// Interfaces: sample stream, command stream and configuration write channel.
interface lnos_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        range_invalid;
  logic        scan_last;
  logic [31:0] now_ms;
  modport source(output valid, range_mm, range_invalid, scan_last, now_ms, input ready);
  modport sink(input valid, range_mm, range_invalid, scan_last, now_ms, output ready);
endinterface

interface lnos_cmd_if;
  logic               valid;
  logic               ready;
  logic [19:0]        forward_speed;
  logic signed [22:0] turn_rate;
  modport source(output valid, forward_speed, turn_rate, input ready);
  modport sink(input valid, forward_speed, turn_rate, output ready);
endinterface

interface lnos_cfg_if;
  import lnos_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

FILE: src/lnos_front.sv
// Front end: running minimum over a scan, hands one record per scan to the queue.
module lnos_front #(
  parameter int MAX_SAMPLES = lnos_pkg::MAX_SAMPLES_DEF,
  parameter int IDX_W       = $clog2(MAX_SAMPLES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  range_mm,
  input  logic                         range_invalid,
  input  logic                         scan_last,
  input  logic [31:0]                  now_ms,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic [lnos_pkg::RANGE_W-1:0] push_range,
  output logic [IDX_W-1:0]             push_index,
  output logic [31:0]                  push_now
);
  import lnos_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  logic [RANGE_W-1:0] best_range;
  logic [IDX_W-1:0]   best_index;
  logic [CNT_W-1:0]   sample_count;

  logic               accept;
  logic               count_ok;
  logic [RANGE_W-1:0] r;
  logic               take;
  logic [RANGE_W-1:0] best_range_next;
  logic [IDX_W-1:0]   best_index_next;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign count_ok = sample_count < CNT_MAX;

  always_comb begin
    // short returns count as far but still join the search
    r = (range_mm < RANGE_SHORT_MM) ? RANGE_FAR : {1'b0, range_mm};
    take = !range_invalid && count_ok && (r < best_range);
    best_range_next = take ? r : best_range;
    best_index_next = take ? sample_count[IDX_W-1:0] : best_index;
  end

  assign push_valid = accept && scan_last;
  assign push_range = best_range_next;
  assign push_index = best_index_next;
  assign push_now   = now_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_range   <= RANGE_INF;
      best_index   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (scan_last) begin
        best_range   <= RANGE_INF;
        best_index   <= '0;
        sample_count <= '0;
      end else begin
        best_range <= best_range_next;
        best_index <= best_index_next;
        if (count_ok) begin
          sample_count <= sample_count + 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/lnos_queue.sv
// Short FIFO of scan records between front and back end.
module lnos_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lnos_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/lnos_back.sv
// Back end: bearing, mode rules, cooldown and the registered command output.
module lnos_back #(
  parameter int IDX_W = $clog2(lnos_pkg::MAX_SAMPLES_DEF)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lnos_pkg::cfg_t               cfg,
  input  logic                         rec_valid,
  output logic                         rec_ready,
  input  logic [lnos_pkg::RANGE_W-1:0] rec_range,
  input  logic [IDX_W-1:0]             rec_index,
  input  logic [31:0]                  rec_now,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [19:0]                  forward_speed,
  output logic signed [22:0]           turn_rate
);
  import lnos_pkg::*;

  localparam int PROD_W = IDX_W + 16;
  localparam int ANG_W  = PROD_W + 2;
  localparam logic signed [ANG_W-1:0] PI_A      = ANG_W'(PI_URAD);
  localparam logic signed [ANG_W-1:0] TWO_PI_A  = ANG_W'(TWO_PI_URAD);
  localparam logic [ANG_W-1:0]        TEN_DEG_A = ANG_W'(TEN_DEG_URAD);

  logic advance;

  // stage 1: products
  logic               v1;
  logic [PROD_W-1:0]  prod1;
  logic [RANGE_W-1:0] range1;
  logic [31:0]        now1;
  logic [17:0]        div6_1;
  logic [21:0]        base3_1;
  logic [41:0]        div6_full;

  // stage 2: raw bearing and its wrapped alternative
  logic                    v2;
  logic signed [ANG_W-1:0] ang2;
  logic signed [ANG_W-1:0] alt2;
  logic [RANGE_W-1:0]      range2;
  logic [31:0]             now2;
  logic [17:0]             div6_2;
  logic [21:0]             base3_2;
  logic signed [ANG_W-1:0] start_ext;
  logic signed [ANG_W-1:0] prod_ext;

  // stage 3: classified scan
  logic        v3;
  logic        in_cone3;
  logic        near3;
  logic        off_axis3;
  logic        beyond3;
  logic        neg3;
  logic        pos3;
  logic [31:0] now3;
  logic [17:0] div6_3;
  logic [21:0] base3_3;
  logic signed [ANG_W-1:0] ang_w;
  logic [ANG_W-1:0]        mag;

  // stage 4: decision
  logic               [31:0] cooldown_until_ms;
  logic               act;
  logic               hold;
  logic [31:0]        hold_ms;
  logic [19:0]        speed;
  logic signed [22:0] turn;
  logic signed [22:0] turn_pos;
  logic signed [22:0] turn_toward;

  assign advance   = !out_valid || out_ready;
  assign rec_ready = advance;

  assign div6_full = cfg.base_speed_umps * DIV6_RECIP;
  assign start_ext = ANG_W'(cfg.scan_start_urad);
  assign prod_ext  = $signed({2'b00, prod1});

  always_comb begin
    ang_w = (ang2 >= PI_A) ? alt2 : ang2;
    mag   = ang_w[ANG_W-1] ? ANG_W'(-ang_w) : ang_w;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod1   <= PROD_W'(cfg.scan_step_urad) * PROD_W'(rec_index);
      range1  <= rec_range;
      now1    <= rec_now;
      div6_1  <= div6_full[DIV6_SHIFT +: 18];
      base3_1 <= {2'b00, cfg.base_speed_umps} + {1'b0, cfg.base_speed_umps, 1'b0};

      ang2    <= start_ext + prod_ext;
      alt2    <= start_ext - TWO_PI_A + prod_ext;
      range2  <= range1;
      now2    <= now1;
      div6_2  <= div6_1;
      base3_2 <= base3_1;

      in_cone3  <= {mag, 1'b0} < (ANG_W + 1)'(cfg.cone_width_urad);
      near3     <= range2 < RANGE_W'(cfg.near_threshold_mm);
      off_axis3 <= mag >= TEN_DEG_A;
      beyond3   <= range2 > FOLLOW_MIN_MM;
      neg3      <= ang_w[ANG_W-1];
      pos3      <= !ang_w[ANG_W-1] && (ang_w != '0);
      now3      <= now2;
      div6_3    <= div6_2;
      base3_3   <= base3_2;
    end
  end

  always_comb begin
    turn_pos    = $signed({1'b0, base3_3});
    // toward the obstacle: +3*base*sign(bearing)
    turn_toward = pos3 ? turn_pos : (neg3 ? -turn_pos : '0);
    act     = v3 && (cfg.run_mode != MODE_IDLE) && !(cooldown_until_ms > now3);
    hold    = 1'b0;
    hold_ms = TRACK_HOLD_MS;
    speed   = '0;
    turn    = '0;
    unique case (cfg.run_mode)
      MODE_AVOID: begin
        if (in_cone3 && near3) begin
          speed   = {2'b00, div6_3};
          turn    = -turn_toward;
          hold    = 1'b1;
          hold_ms = AVOID_HOLD_MS;
        end else begin
          speed = cfg.base_speed_umps;
        end
      end
      MODE_FOLLOW: begin
        if (in_cone3 && near3 && off_axis3) begin
          speed = CRAWL_UMPS;
          turn  = turn_toward;
          hold  = 1'b1;
        end else if (in_cone3 && near3 && beyond3) begin
          speed = cfg.base_speed_umps;
          hold  = 1'b1;
        end
      end
      MODE_GUARD: begin
        if (near3 && off_axis3) begin
          speed = CRAWL_UMPS;
          turn  = turn_toward;
          hold  = 1'b1;
        end
      end
      default: begin
        speed = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1                <= 1'b0;
      v2                <= 1'b0;
      v3                <= 1'b0;
      out_valid         <= 1'b0;
      cooldown_until_ms <= '0;
    end else if (advance) begin
      v1        <= rec_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= act;
      if (act && hold) begin
        cooldown_until_ms <= now3 + hold_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && act) begin
      forward_speed <= speed;
      turn_rate     <= turn;
    end
  end

endmodule

FILE: src/lidar_nearest_obstacle_steer_core.sv
// Each scan record passes the queue, stages 1 to 3 and the output register.
// Throughput: one sample per cycle while the queue has room, scan ends included.
// The back end runs a four-stage pipe; the cooldown loop stays inside the last stage.
// A four-record queue lets the sample side run while the command output stalls.
// Reset (synchronous, active high) restores the register defaults, clears the scan
// minimum, the cooldown and all valid flags.
module lidar_nearest_obstacle_steer_core #(
  parameter int MAX_SAMPLES = lnos_pkg::MAX_SAMPLES_DEF
) (
  input logic         clk,
  input logic         rst,
  lnos_sample_if.sink sample,
  lnos_cmd_if.source  cmd,
  lnos_cfg_if.sink    cfg
);
  import lnos_pkg::*;

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int REC_W = RANGE_W + IDX_W + 32;

  cfg_t regs;

  logic               push_valid;
  logic               push_ready;
  logic [RANGE_W-1:0] push_range;
  logic [IDX_W-1:0]   push_index;
  logic [31:0]        push_now;
  logic               pop_valid;
  logic               pop_ready;
  logic [REC_W-1:0]   pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.run_mode          <= MODE_IDLE;
      regs.near_threshold_mm <= 11'd300;
      regs.cone_width_urad   <= 23'd1570796;
      regs.base_speed_umps   <= 20'd120000;
      regs.scan_start_urad   <= -24'sd3141593;
      regs.scan_step_urad    <= 16'd3068;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        CFG_RUN_MODE:   regs.run_mode          <= mode_t'(cfg.data[1:0]);
        CFG_NEAR_MM:    regs.near_threshold_mm <= cfg.data[10:0];
        CFG_CONE_URAD:  regs.cone_width_urad   <= cfg.data[22:0];
        CFG_BASE_UMPS:  regs.base_speed_umps   <= cfg.data[19:0];
        CFG_START_URAD: regs.scan_start_urad   <= $signed(cfg.data[23:0]);
        CFG_STEP_URAD:  regs.scan_step_urad    <= cfg.data[15:0];
        default: begin
          // drop writes to unused addresses
        end
      endcase
    end
  end

  lnos_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .range_mm     (sample.range_mm),
    .range_invalid(sample.range_invalid),
    .scan_last    (sample.scan_last),
    .now_ms       (sample.now_ms),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_range   (push_range),
    .push_index   (push_index),
    .push_now     (push_now)
  );

  lnos_queue #(
    .WIDTH(REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_range, push_index, push_now}),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  lnos_back #(
    .IDX_W(IDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (regs),
    .rec_valid    (pop_valid),
    .rec_ready    (pop_ready),
    .rec_range    (pop_data[REC_W-1 -: RANGE_W]),
    .rec_index    (pop_data[32 +: IDX_W]),
    .rec_now      (pop_data[31:0]),
    .out_valid    (cmd.valid),
    .out_ready    (cmd.ready),
    .forward_speed(cmd.forward_speed),
    .turn_rate    (cmd.turn_rate)
  );

endmodule

FILE: verif/lnos_steer_checker.sv
// Checker: mirrors the registers, predicts each steering command and compares the output.
module lnos_steer_checker #(
  parameter int MAX_SAMPLES = 2048
) (
  input  logic   clk,
  input  logic   rst,
  lnos_sample_if sample,
  lnos_cmd_if    cmd,
  lnos_cfg_if    cfg,
  output int     mismatches,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lnos_pkg::*;

  typedef struct packed {
    logic [19:0]        speed;
    logic signed [22:0] turn;
  } steer_cmd_t;

  steer_cmd_t          expected_cmds[$];
  cfg_t                regs;
  logic [RANGE_W-1:0]  nearest_mm;
  logic [10:0]         nearest_idx;
  int                  scan_pos;
  logic [31:0]         hold_until_ms;
  int                  err_cnt = 0;

  task automatic clear_scan();
    nearest_mm  = RANGE_INF;
    nearest_idx = '0;
    scan_pos    = 0;
  endtask

  // Fold one sample into the running minimum; at scan end work out the command.
  task automatic absorb_sample(input logic [15:0] rng_mm, input logic invalid,
                               input logic last, input logic [31:0] now);
    logic [RANGE_W-1:0] r;
    logic [RANGE_W-1:0] gap_mm;
    longint             bearing, mag, sgn, turn3, turn;
    logic               in_cone, is_near, off_axis;
    steer_cmd_t         c;
    if (!invalid && scan_pos < MAX_SAMPLES) begin
      r = (rng_mm < RANGE_SHORT_MM) ? RANGE_FAR : {1'b0, rng_mm};
      if (r < nearest_mm) begin
        nearest_mm  = r;
        nearest_idx = scan_pos[10:0];
      end
    end
    if (scan_pos < MAX_SAMPLES) scan_pos++;
    if (!last) return;

    bearing = longint'(regs.scan_start_urad)
            + longint'(regs.scan_step_urad) * longint'(nearest_idx);
    // wrap once only
    if (bearing >= PI_URAD) bearing -= TWO_PI_URAD;
    mag      = (bearing < 0) ? -bearing : bearing;
    sgn      = (bearing > 0) ? 1 : ((bearing < 0) ? -1 : 0);
    in_cone  = (2 * mag) < longint'(regs.cone_width_urad);
    is_near  = nearest_mm < regs.near_threshold_mm;
    off_axis = mag >= TEN_DEG_URAD;
    turn3    = 3 * longint'(regs.base_speed_umps);
    gap_mm   = nearest_mm;
    clear_scan();

    if (regs.run_mode == MODE_IDLE || hold_until_ms > now) return;

    c.speed = '0;
    turn    = 0;
    case (regs.run_mode)
      MODE_AVOID: begin
        if (in_cone && is_near) begin
          c.speed       = 20'(regs.base_speed_umps / 6);
          turn          = -turn3 * sgn;
          hold_until_ms = now + AVOID_HOLD_MS;
        end else begin
          c.speed = regs.base_speed_umps;
        end
      end
      MODE_FOLLOW: begin
        if (in_cone && is_near && off_axis) begin
          c.speed       = CRAWL_UMPS;
          turn          = turn3 * sgn;
          hold_until_ms = now + TRACK_HOLD_MS;
        end else if (in_cone && is_near && gap_mm > FOLLOW_MIN_MM) begin
          c.speed       = regs.base_speed_umps;
          hold_until_ms = now + TRACK_HOLD_MS;
        end
      end
      default: begin
        // guard: no cone test
        if (is_near && off_axis) begin
          c.speed       = CRAWL_UMPS;
          turn          = turn3 * sgn;
          hold_until_ms = now + TRACK_HOLD_MS;
        end
      end
    endcase
    c.turn = turn[22:0];
    expected_cmds.push_back(c);
  endtask

  always @(posedge clk) begin : monitor
    steer_cmd_t want;
    if (rst) begin
      regs.run_mode          = MODE_IDLE;
      regs.near_threshold_mm = 11'd300;
      regs.cone_width_urad   = 23'd1570796;
      regs.base_speed_umps   = 20'd120000;
      regs.scan_start_urad   = -24'sd3141593;
      regs.scan_step_urad    = 16'd3068;
      hold_until_ms          = '0;
      clear_scan();
      expected_cmds.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_addr_t'(cfg.addr))
          CFG_RUN_MODE:   regs.run_mode          = mode_t'(cfg.data[1:0]);
          CFG_NEAR_MM:    regs.near_threshold_mm = cfg.data[10:0];
          CFG_CONE_URAD:  regs.cone_width_urad   = cfg.data[22:0];
          CFG_BASE_UMPS:  regs.base_speed_umps   = cfg.data[19:0];
          CFG_START_URAD: regs.scan_start_urad   = cfg.data[23:0];
          CFG_STEP_URAD:  regs.scan_step_urad    = cfg.data[15:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        absorb_sample(sample.range_mm, sample.range_invalid, sample.scan_last, sample.now_ms);
      if (cmd.valid && cmd.ready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: command speed=%0d turn=%0d arrived with none expected",
                   $time, cmd.forward_speed, cmd.turn_rate);
          err_cnt++;
        end else begin
          want = expected_cmds.pop_front();
          if (cmd.forward_speed !== want.speed) begin
            $display("%0t: forward_speed expected %0d, got %0d",
                     $time, want.speed, cmd.forward_speed);
            err_cnt++;
          end
          if (cmd.turn_rate !== want.turn) begin
            $display("%0t: turn_rate expected %0d, got %0d",
                     $time, want.turn, cmd.turn_rate);
            err_cnt++;
          end
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= expected_cmds.size();
  end

endmodule

FILE: verif/tb_lidar_nearest_obstacle_steer_core.sv
// Testbench top: clock, reset, sample and register stimulus, command back-pressure, verdict.
module tb_lidar_nearest_obstacle_steer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lnos_pkg::*;

  // small scan cap so that overlong scans stay short
  localparam int SCAN_CAP = 256;

  logic clk;
  logic rst;
  logic hold_req;
  int   mismatches;
  int   outstanding;

  bit          offering;
  bit          steady;
  int          burst_left;
  logic [31:0] clock_ms;
  int          random_items;

  lnos_sample_if sample_ch();
  lnos_cmd_if    cmd_ch();
  lnos_cfg_if    cfg_ch();

  lidar_nearest_obstacle_steer_core #(.MAX_SAMPLES(SCAN_CAP)) u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .cmd    (cmd_ch),
    .cfg    (cfg_ch)
  );

  lnos_steer_checker #(.MAX_SAMPLES(SCAN_CAP)) u_chk (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .cmd         (cmd_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_lidar_nearest_obstacle_steer_core: done, errors");
    $finish;
  end

  // Command side: changing stall styles, plus one long hold-off on request.
  initial begin : cmd_stall
    int style;
    int left;
    bit long_hold_done;
    style          = 0;
    left           = 0;
    long_hold_done = 0;
    cmd_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !long_hold_done) begin
        long_hold_done = 1;
        cmd_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left  = $urandom_range(50, 300);
        end
        left--;
        case (style)
          0:       cmd_ch.ready <= 1'b1;
          1:       cmd_ch.ready <= 1'($urandom_range(0, 1));
          2:       cmd_ch.ready <= ($urandom_range(0, 3) == 0);
          default: cmd_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offer one item and hold until taken; drop valid for a random gap at burst end.
  task automatic offer(input logic [15:0] rng_mm, input logic invalid, input logic last,
                       input logic [31:0] now);
    sample_ch.valid         <= 1'b1;
    sample_ch.range_mm      <= rng_mm;
    sample_ch.range_invalid <= invalid;
    sample_ch.scan_last     <= last;
    sample_ch.now_ms        <= now;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    offering = 1;
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        sample_ch.valid <= 1'b0;
        offering = 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
    end
  endtask

  // Wait for every command in flight, then let the pipe drain.
  task automatic settle();
    if (offering) begin
      sample_ch.valid <= 1'b0;
      offering = 0;
    end
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_addr_t   slot[6];
    logic [23:0] value[6];
    slot  = '{CFG_RUN_MODE, CFG_NEAR_MM, CFG_CONE_URAD, CFG_BASE_UMPS,
              CFG_START_URAD, CFG_STEP_URAD};
    value = '{{22'd0, c.run_mode}, {13'd0, c.near_threshold_mm}, {1'b0, c.cone_width_urad},
              {4'd0, c.base_speed_umps}, c.scan_start_urad, {8'd0, c.scan_step_urad}};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.addr  <= slot[i];
      cfg_ch.data  <= value[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic cfg_t make_cfg(input mode_t mode, input int thr, input int cone,
                                    input int base, input int start, input int step);
    cfg_t c;
    c.run_mode          = mode;
    c.near_threshold_mm = 11'(thr);
    c.cone_width_urad   = 23'(cone);
    c.base_speed_umps   = 20'(base);
    c.scan_start_urad   = 24'(start);
    c.scan_step_urad    = 16'(step);
    return c;
  endfunction

  // Lean on the ends of the range.
  function automatic int pick_in(input int lo, input int hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return lo;
    if (roll < 30) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic cfg_t random_cfg();
    mode_t mode;
    int    start;
    int    step;
    mode  = ($urandom_range(0, 9) == 0) ? MODE_IDLE : mode_t'($urandom_range(1, 3));
    start = ($urandom_range(0, 9) < 3) ? int'($urandom_range(0, 400000)) - 200000
                                       : pick_in(-6283185, 6283185);
    step  = ($urandom_range(0, 9) < 4) ? int'($urandom_range(0, 3000)) : pick_in(0, 65535);
    return make_cfg(mode, pick_in(300, 1500), pick_in(0, 6283185), pick_in(1, 1000000),
                    start, step);
  endfunction

  task automatic random_scan(input int len, input bit all_invalid);
    logic [15:0] rng_mm;
    logic        invalid;
    int          roll;
    for (int k = 0; k < len; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10)      rng_mm = 16'($urandom_range(0, 49));
      else if (roll < 35) rng_mm = 16'($urandom_range(50, 1600));
      else if (roll < 40) rng_mm = 16'hFFFF;
      else                rng_mm = 16'($urandom_range(1601, 65535));
      invalid = all_invalid || ($urandom_range(0, 9) == 0);
      if (k == len - 1) begin
        roll = $urandom_range(0, 99);
        if (roll < 80)      clock_ms = clock_ms + $urandom_range(0, 600);
        else if (roll < 95) clock_ms = clock_ms + $urandom_range(600, 5000);
        else                clock_ms = $urandom();
        offer(rng_mm, invalid, 1'b1, clock_ms);
      end else begin
        offer(rng_mm, invalid, 1'b0, $urandom());
      end
      random_items++;
    end
  endtask

  initial begin : stimulus
    int phase;
    int len;
    rst                     <= 1'b1;
    hold_req                <= 1'b0;
    sample_ch.valid         <= 1'b0;
    sample_ch.range_mm      <= '0;
    sample_ch.range_invalid <= 1'b0;
    sample_ch.scan_last     <= 1'b0;
    sample_ch.now_ms        <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.addr             <= '0;
    cfg_ch.data             <= '0;
    offering     = 0;
    steady       = 0;
    burst_left   = 1;
    clock_ms     = 32'h0001_0000;
    random_items = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle after reset: scan end gives nothing
    offer(16'hFFFF, 1'b0, 1'b1, 32'd0);
    settle();

    // short returns, boundary at 50 mm, register extremes, wide negative bearing
    load_config(make_cfg(MODE_AVOID, 1500, 6283185, 1000000, -6283185, 65535));
    offer(16'd0, 1'b0, 1'b0, 32'd0);
    offer(16'd49, 1'b0, 1'b0, 32'd0);
    offer(16'd50, 1'b0, 1'b0, 32'd0);
    offer(16'hFFFF, 1'b0, 1'b1, 32'd0);
    offer(16'd100, 1'b1, 1'b0, 32'd0);
    offer(16'd200, 1'b0, 1'b1, 32'd1000);
    settle();

    // avoid straight ahead with cooldown wrapping past 2^32
    load_config(make_cfg(MODE_AVOID, 300, 6283185, 1, 0, 0));
    offer(16'd100, 1'b0, 1'b1, 32'hFFFF_FE00);
    offer(16'd100, 1'b0, 1'b1, 32'h0000_0050);
    offer(16'hFFFF, 1'b0, 1'b1, 32'h0000_0200);
    settle();

    // follow: on axis, off axis, whole scan invalid, too close to follow
    load_config(make_cfg(MODE_FOLLOW, 1500, 6283185, 1000000, 0, 65535));
    offer(16'd1000, 1'b0, 1'b1, 32'h1000);
    offer(16'd2000, 1'b0, 1'b0, 32'h0);
    offer(16'd2000, 1'b0, 1'b0, 32'h0);
    offer(16'd2000, 1'b0, 1'b0, 32'h0);
    offer(16'd800, 1'b0, 1'b1, 32'h2000);
    offer(16'd200, 1'b1, 1'b0, 32'h0);
    offer(16'd300, 1'b1, 1'b1, 32'h3000);
    offer(16'd340, 1'b0, 1'b1, 32'h4000);
    settle();

    // guard off axis, then blocked by its own cooldown
    load_config(make_cfg(MODE_GUARD, 300, 0, 1000000, -1000000, 65535));
    offer(16'd100, 1'b0, 1'b1, 32'h5000);
    offer(16'd100, 1'b0, 1'b1, 32'h5010);
    settle();

    // bearing exactly at pi wraps to just above minus pi
    load_config(make_cfg(MODE_AVOID, 1500, 6283185, 600000, 3141593, 0));
    offer(16'd100, 1'b0, 1'b1, 32'h6000);
    settle();

    // fill the block while the command side holds off
    load_config(make_cfg(MODE_AVOID, 300, 0, 500000, 0, 100));
    steady = 1;
    hold_req <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      clock_ms = clock_ms + 1;
      offer(16'd60000, 1'b0, 1'b1, clock_ms);
    end
    steady     = 0;
    burst_left = 1;
    settle();

    phase = 0;
    while (random_items < 1000) begin
      load_config(random_cfg());
      steady     = ($urandom_range(0, 4) == 0);
      burst_left = 1;
      if (phase == 4 || phase == 9)
        random_scan(SCAN_CAP + $urandom_range(1, 50), 1'b0);
      repeat ($urandom_range(4, 20)) begin
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        random_scan(len, $urandom_range(0, 9) == 0);
      end
      steady = 0;
      settle();
      phase++;
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_lidar_nearest_obstacle_steer_core: done, clean");
    end else begin
      $display("tb_lidar_nearest_obstacle_steer_core: done, errors");
    end
    $finish;
  end

endmodule

FILE: lidar_nearest_obstacle_steer_core.f
src/lnos_pkg.sv
src/lnos_if.sv
src/lnos_front.sv
src/lnos_queue.sv
src/lnos_back.sv
src/lidar_nearest_obstacle_steer_core.sv
verif/lnos_steer_checker.sv
verif/tb_lidar_nearest_obstacle_steer_core.sv
